/* src/differential_drive_odometry_unit_macros.svh */
// Assertion macros shared by the odometry checker.
// Each macro expects clk and rst to be visible where it is used.
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_UNIT_MACROS_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_UNIT_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define DDO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after any reset cycle.
`define DDO_ASSERT_RESET(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) \
    else $error(msg);

`endif

/* src/ddo_pkg.sv */
// Shared types and constants for the differential drive odometry unit.
// No dependencies; imported by ddo_muldiv, ddo_cordic and the top level.
`default_nettype none

package ddo_pkg;

  typedef enum logic {
    OP_MUL,
    OP_DIV
  } ddo_op_t;

  // Request from the sequencer to the shared multiply/divide unit.
  typedef struct packed {
    logic    start;
    ddo_op_t op;
  } ddo_req_t;

  localparam int          CFG_IDX_W             = 8;
  localparam int          CFG_DATA_W            = 16;
  localparam logic [7:0]  REG_TICK_LENGTH       = 8'd0;
  localparam logic [7:0]  REG_INV_TRACK_WIDTH   = 8'd1;
  localparam logic [15:0] TICK_LENGTH_RESET     = 16'd5462;
  localparam logic [15:0] INV_TRACK_WIDTH_RESET = 16'd2789;

  // 2^32 / (2 pi) and 2^33 / pi, both rounded.
  localparam logic [31:0] INV_2PI_Q32     = 32'd683565276;
  localparam logic [31:0] TWO_OVER_PI_Q32 = 32'd2734261102;

  localparam logic signed [32:0] CORDIC_START = 33'sd652032874;
  localparam logic [48:0]        STEP_CAP     = 49'h1_0000_0000_0000;

  localparam logic signed [50:0] POS_MAX = 51'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [50:0] POS_MIN = -51'sh0_8000_0000_0000;

  function automatic logic [31:0] atan_bam(input logic [4:0] k);
    logic [31:0] r;
    unique case (k)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* src/ddo_muldiv.sv */
// Shared bit-serial multiply and restoring divide unit, one bit per cycle.
// Both operations run through the same adder. Depends on ddo_pkg.
`default_nettype none

module ddo_muldiv #(
  parameter int W  = 106,
  parameter int CW = 7
) (
  input  logic            clk,
  input  logic            rst,
  input  ddo_pkg::ddo_req_t req,
  input  logic [W-1:0]    a,
  input  logic [W-1:0]    b,
  input  logic [CW-1:0]   steps,
  output logic            done,
  output logic [W-1:0]    result
);
  import ddo_pkg::*;

  logic          busy;
  logic [CW-1:0] cnt;
  ddo_op_t       op;
  logic [W:0]    acc;
  logic [W-1:0]  mc;
  logic [W-1:0]  mp;
  logic [W:0]    op_a;
  logic [W:0]    op_b;
  logic [W+1:0]  sum;
  logic          ge;

  // For a divide the adder subtracts the divisor from the shifted remainder,
  // and its carry out says whether the quotient bit is one.
  always_comb begin
    op_a = (op == OP_DIV) ? {acc[W-1:0], mp[W-1]} : acc;
    op_b = (op == OP_DIV) ? ~{1'b0, mc} : {1'b0, mc};
    sum  = {1'b0, op_a} + {1'b0, op_b} + (W+2)'(op == OP_DIV);
    ge   = sum[W+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= steps;
        op   <= req.op;
        acc  <= '0;
        mc   <= (req.op == OP_DIV) ? b : a;
        mp   <= (req.op == OP_DIV) ? a : b;
      end else if (busy) begin
        unique case (op)
          OP_MUL: begin
            if (mp[0]) acc <= sum[W:0];
            mc <= {mc[W-2:0], 1'b0};
            mp <= {1'b0, mp[W-1:1]};
          end
          OP_DIV: begin
            acc <= ge ? sum[W:0] : op_a;
            mp  <= {mp[W-2:0], ge};
          end
        endcase
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign result = (op == OP_DIV) ? mp : acc[W-1:0];

endmodule

`default_nettype wire

/* src/ddo_cordic.sv */
// Iterative CORDIC rotation giving sine and cosine in Q30, one step per cycle.
// Depends on ddo_pkg for the arctangent table and start vector.
`default_nettype none

module ddo_cordic #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [31:0]        ang,
  output logic               done,
  output logic signed [32:0] sn,
  output logic signed [32:0] cs
);
  import ddo_pkg::*;

  localparam int IW = $clog2(CORDIC_STEPS);

  logic               busy;
  logic [IW-1:0]      idx;
  logic               flip;
  logic signed [32:0] x;
  logic signed [32:0] y;
  logic signed [32:0] z;
  logic signed [32:0] z0;
  logic               flip0;
  logic signed [32:0] xs;
  logic signed [32:0] ys;
  logic signed [32:0] at;

  // Angles beyond a quarter turn either way are rotated by half a turn first.
  always_comb begin
    z0    = $signed({ang[31], ang});
    flip0 = (z0 > 33'sd1073741824) || (z0 < -33'sd1073741824);
    if (flip0) z0 = $signed({~ang[31], ~ang[31], ang[30:0]});
    xs = x >>> idx;
    ys = y >>> idx;
    at = $signed({1'b0, atan_bam(5'(idx))});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        idx  <= '0;
        flip <= flip0;
        x    <= CORDIC_START;
        y    <= '0;
        z    <= z0;
      end else if (busy) begin
        if (!z[32]) begin
          x <= x - ys;
          y <= y + xs;
          z <= z - at;
        end else begin
          x <= x + ys;
          y <= y - xs;
          z <= z + at;
        end
        idx <= idx + IW'(1);
        if (idx == IW'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign sn = flip ? -y : y;
  assign cs = flip ? -x : x;

endmodule

`default_nettype wire

/* src/differential_drive_odometry_unit.sv */
// Top level of the differential drive odometry unit: sequencer and state.
// Depends on ddo_pkg, ddo_muldiv and ddo_cordic.
`default_nettype none

// Dead-reckoning odometry for a two-wheeled robot. Each input transaction
// carries the signed encoder ticks of both wheels; the unit updates x, y
// (Q32.16 cm) and the heading (binary angle) and returns one result
// transaction with whole-cm position and heading. All products and the arc
// division go through one bit-serial multiply/divide unit, one bit per cycle,
// and sine and cosine through an iterative CORDIC. The serial divide runs
// twice per arc step and is the longest operation of a step. The block
// takes no new transaction while one is in progress. There is no clearing
// pass after reset.
module differential_drive_odometry_unit #(
  parameter int TICK_BITS    = 12,
  parameter int CORDIC_STEPS = 24
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [ddo_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ddo_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             item_valid,
  output logic                             item_ready,
  input  logic signed [TICK_BITS-1:0]      left_ticks,
  input  logic signed [TICK_BITS-1:0]      right_ticks,
  output logic                             result_valid,
  input  logic                             result_ready,
  output logic signed [15:0]               pos_x_cm,
  output logic signed [15:0]               pos_y_cm,
  output logic [31:0]                      heading_angle
);
  import ddo_pkg::*;

  localparam int MAG_W = TICK_BITS + 1;
  localparam int SW    = TICK_BITS + 16;
  localparam int TW    = TICK_BITS + 30;
  localparam int W     = TICK_BITS + 82;
  localparam int CW    = $clog2(W + 1);

  typedef enum logic [4:0] {
    ST_IDLE, ST_M1, ST_MP, ST_MT, ST_MS, ST_COR0, ST_MX, ST_MY, ST_COR1,
    ST_NX1, ST_NX2, ST_DX, ST_NY1, ST_NY2, ST_DY, ST_UPD, ST_DONE
  } state_t;

  state_t              state;
  logic                launched;
  logic [15:0]         tick_length;
  logic [15:0]         inv_track;
  logic signed [47:0]  pos_x;
  logic signed [47:0]  pos_y;
  logic [31:0]         heading;

  logic                sum_neg;
  logic                diff_neg;
  logic [MAG_W-1:0]    sum_mag;
  logic [MAG_W-1:0]    diff_mag;
  logic [W-1:0]        prod;
  logic [TW-1:0]       tmag;
  logic [SW-1:0]       smag;
  logic signed [32:0]  s0;
  logic signed [32:0]  c0;
  logic signed [32:0]  s1;
  logic signed [32:0]  c1;
  logic [48:0]         stepx_mag;
  logic [48:0]         stepy_mag;
  logic                stepx_neg;
  logic                stepy_neg;

  logic signed [MAG_W-1:0] in_sum;
  logic signed [MAG_W-1:0] in_diff;
  logic [31:0]         t_low;
  logic [31:0]         hn;
  logic signed [33:0]  dc;
  logic signed [33:0]  ds;
  logic [33:0]         dc_mag;
  logic [33:0]         ds_mag;
  logic [32:0]         s0_mag;
  logic [32:0]         c0_mag;

  ddo_req_t            mul_req;
  logic                mul_go;
  logic [W-1:0]        mul_a;
  logic [W-1:0]        mul_b;
  logic [CW-1:0]       mul_steps;
  logic                mul_done;
  logic [W-1:0]        mul_res;
  logic                cor_start;
  logic [31:0]         cor_ang;
  logic                cor_done;
  logic signed [32:0]  cor_sn;
  logic signed [32:0]  cor_cs;

  function automatic logic [48:0] cap_step(input logic [W-1:0] v);
    logic [48:0] r;
    if ((|v[W-1:49]) || (v[48] && (|v[47:0]))) r = STEP_CAP;
    else r = v[48:0];
    return r;
  endfunction

  function automatic logic signed [47:0] sat_add(input logic signed [47:0] p,
                                                 input logic [48:0] m,
                                                 input logic n);
    logic signed [50:0] st;
    logic signed [50:0] r;
    st = n ? -$signed({2'b00, m}) : $signed({2'b00, m});
    r  = $signed({{3{p[47]}}, p}) + st;
    if (r > POS_MAX) r = POS_MAX;
    else if (r < POS_MIN) r = POS_MIN;
    return r[47:0];
  endfunction

  // Whole centimetres, truncated toward zero and saturated to 16 bits.
  function automatic logic [15:0] out_cm(input logic signed [47:0] p);
    logic [47:0] mag;
    logic [31:0] w;
    logic [15:0] r;
    mag = p[47] ? 48'(-p) : 48'(p);
    w   = mag[47:16];
    if (p[47]) r = (w > 32'd32768) ? 16'h8000 : 16'(-w);
    else r = (w > 32'd32767) ? 16'h7FFF : w[15:0];
    return r;
  endfunction

  always_comb begin
    in_sum  = $signed({left_ticks[TICK_BITS-1], left_ticks})
            + $signed({right_ticks[TICK_BITS-1], right_ticks});
    in_diff = $signed({left_ticks[TICK_BITS-1], left_ticks})
            - $signed({right_ticks[TICK_BITS-1], right_ticks});
    t_low   = diff_neg ? -tmag[31:0] : tmag[31:0];
    hn      = heading + t_low;
    dc      = $signed({c0[32], c0}) - $signed({c1[32], c1});
    ds      = $signed({s1[32], s1}) - $signed({s0[32], s0});
    dc_mag  = dc[33] ? 34'(-dc) : 34'(dc);
    ds_mag  = ds[33] ? 34'(-ds) : 34'(ds);
    s0_mag  = s0[32] ? 33'(-s0) : 33'(s0);
    c0_mag  = c0[32] ? 33'(-c0) : 33'(c0);
  end

  always_comb begin
    mul_go    = 1'b0;
    mul_req   = '{start: 1'b0, op: OP_MUL};
    mul_a     = '0;
    mul_b     = '0;
    mul_steps = '0;
    cor_start = 1'b0;
    cor_ang   = heading;
    unique case (state)
      ST_M1: begin
        mul_go = 1'b1; mul_a = W'(tick_length); mul_b = W'(inv_track);
        mul_steps = CW'(16);
      end
      ST_MP: begin
        mul_go = 1'b1; mul_a = prod; mul_b = W'(diff_mag); mul_steps = CW'(MAG_W);
      end
      ST_MT: begin
        mul_go = 1'b1; mul_a = prod; mul_b = W'(INV_2PI_Q32); mul_steps = CW'(30);
      end
      ST_MS: begin
        mul_go = 1'b1; mul_a = W'(tick_length); mul_b = W'(sum_mag);
        mul_steps = CW'(MAG_W);
      end
      ST_COR0: cor_start = !launched;
      ST_MX: begin
        mul_go = 1'b1; mul_a = W'(smag); mul_b = W'(s0_mag); mul_steps = CW'(33);
      end
      ST_MY: begin
        mul_go = 1'b1; mul_a = W'(smag); mul_b = W'(c0_mag); mul_steps = CW'(33);
      end
      ST_COR1: begin
        cor_start = !launched;
        cor_ang   = hn;
      end
      ST_NX1: begin
        mul_go = 1'b1; mul_a = W'(smag); mul_b = W'(dc_mag); mul_steps = CW'(34);
      end
      ST_NY1: begin
        mul_go = 1'b1; mul_a = W'(smag); mul_b = W'(ds_mag); mul_steps = CW'(34);
      end
      ST_NX2, ST_NY2: begin
        mul_go = 1'b1; mul_a = prod; mul_b = W'(TWO_OVER_PI_Q32);
        mul_steps = CW'(32);
      end
      ST_DX, ST_DY: begin
        mul_go = 1'b1; mul_req.op = OP_DIV; mul_a = prod; mul_b = W'(tmag);
        mul_steps = CW'(W);
      end
      default: ;
    endcase
    mul_req.start = mul_go && !launched;
  end

  ddo_muldiv #(.W(W), .CW(CW)) u_muldiv (
    .clk    (clk),
    .rst    (rst),
    .req    (mul_req),
    .a      (mul_a),
    .b      (mul_b),
    .steps  (mul_steps),
    .done   (mul_done),
    .result (mul_res)
  );

  ddo_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cor_start),
    .ang   (cor_ang),
    .done  (cor_done),
    .sn    (cor_sn),
    .cs    (cor_cs)
  );

  assign item_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      launched     <= 1'b0;
      result_valid <= 1'b0;
      tick_length  <= TICK_LENGTH_RESET;
      inv_track    <= INV_TRACK_WIDTH_RESET;
      pos_x        <= '0;
      pos_y        <= '0;
      heading      <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_TICK_LENGTH) tick_length <= cfg_data;
        else if (cfg_index == REG_INV_TRACK_WIDTH) inv_track <= cfg_data;
      end
      // In ST_DONE the result register is refilled below instead.
      if (result_valid && result_ready && state != ST_DONE) result_valid <= 1'b0;

      if (mul_go || state == ST_COR0 || state == ST_COR1) begin
        if (!launched) launched <= 1'b1;
      end

      unique case (state)
        ST_IDLE: begin
          if (item_valid) begin
            sum_neg  <= in_sum[MAG_W-1];
            diff_neg <= in_diff[MAG_W-1];
            sum_mag  <= in_sum[MAG_W-1] ? MAG_W'(-in_sum) : MAG_W'(in_sum);
            diff_mag <= in_diff[MAG_W-1] ? MAG_W'(-in_diff) : MAG_W'(in_diff);
            state    <= ST_M1;
          end
        end
        ST_M1: if (launched && mul_done) begin
          prod <= mul_res; launched <= 1'b0; state <= ST_MP;
        end
        ST_MP: if (launched && mul_done) begin
          prod <= mul_res; launched <= 1'b0; state <= ST_MT;
        end
        ST_MT: if (launched && mul_done) begin
          tmag <= mul_res[TW+31:32]; launched <= 1'b0; state <= ST_MS;
        end
        ST_MS: if (launched && mul_done) begin
          smag <= mul_res[SW-1:0]; launched <= 1'b0; state <= ST_COR0;
        end
        ST_COR0: if (launched && cor_done) begin
          s0 <= cor_sn; c0 <= cor_cs; launched <= 1'b0;
          state <= (tmag == '0) ? ST_MX : ST_COR1;
        end
        ST_MX: if (launched && mul_done) begin
          stepx_mag <= cap_step(mul_res >> 31);
          stepx_neg <= sum_neg ^ s0[32];
          launched  <= 1'b0;
          state     <= ST_MY;
        end
        ST_MY: if (launched && mul_done) begin
          stepy_mag <= cap_step(mul_res >> 31);
          stepy_neg <= sum_neg ^ c0[32];
          launched  <= 1'b0;
          state     <= ST_UPD;
        end
        ST_COR1: if (launched && cor_done) begin
          s1 <= cor_sn; c1 <= cor_cs; launched <= 1'b0; state <= ST_NX1;
        end
        ST_NX1: if (launched && mul_done) begin
          prod <= mul_res; launched <= 1'b0; state <= ST_NX2;
        end
        ST_NX2: if (launched && mul_done) begin
          prod <= mul_res; launched <= 1'b0; state <= ST_DX;
        end
        ST_DX: if (launched && mul_done) begin
          stepx_mag <= cap_step(mul_res >> 33);
          stepx_neg <= sum_neg ^ dc[33] ^ diff_neg;
          launched  <= 1'b0;
          state     <= ST_NY1;
        end
        ST_NY1: if (launched && mul_done) begin
          prod <= mul_res; launched <= 1'b0; state <= ST_NY2;
        end
        ST_NY2: if (launched && mul_done) begin
          prod <= mul_res; launched <= 1'b0; state <= ST_DY;
        end
        ST_DY: if (launched && mul_done) begin
          stepy_mag <= cap_step(mul_res >> 33);
          stepy_neg <= sum_neg ^ ds[33] ^ diff_neg;
          launched  <= 1'b0;
          state     <= ST_UPD;
        end
        ST_UPD: begin
          pos_x <= sat_add(pos_x, stepx_mag, stepx_neg);
          pos_y <= sat_add(pos_y, stepy_mag, stepy_neg);
          if (tmag != '0) heading <= hn;
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!result_valid || result_ready) begin
            pos_x_cm      <= out_cm(pos_x);
            pos_y_cm      <= out_cm(pos_y);
            heading_angle <= heading;
            result_valid  <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* src/ddo_checker.sv */
// Port-level checker for the differential drive odometry unit, bound to the top.
// Depends on differential_drive_odometry_unit_macros.svh.
`default_nettype none

`include "differential_drive_odometry_unit_macros.svh"

module ddo_checker (
  input logic        clk,
  input logic        rst,
  input logic        item_valid,
  input logic        item_ready,
  input logic        result_valid,
  input logic        result_ready,
  input logic [31:0] heading_angle
);

  // A stalled result transaction keeps its heading.
  `DDO_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(heading_angle), "stalled result changed")

  // Once a transaction is taken the unit is busy computing it.
  `DDO_ASSERT_NEXT(a_busy_after_take, item_valid && item_ready, !item_ready, "ready stayed high after a transaction")

  // No result can appear in the cycle after a transaction is taken.
  `DDO_ASSERT_NEXT(a_no_instant_result, item_valid && item_ready, !$rose(result_valid), "result appeared too early")

  // Reset leaves the unit idle with no pending result.
  `DDO_ASSERT_RESET(a_reset_idle, item_ready && !result_valid, "unit not idle after reset")

endmodule

bind differential_drive_odometry_unit ddo_checker u_ddo_checker (
  .clk           (clk),
  .rst           (rst),
  .item_valid    (item_valid),
  .item_ready    (item_ready),
  .result_valid  (result_valid),
  .result_ready  (result_ready),
  .heading_angle (heading_angle)
);

`default_nettype wire

/* test/tb_top.sv */
// Testbench for the differential drive odometry unit: a directed table, then random phases.
// Depends on ddo_pkg and differential_drive_odometry_unit; holds its own pose predictor.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ddo_pkg::*;

  localparam int          TICKS_W   = 12;
  localparam int          LIMIT     = 2_000_000;
  localparam logic [7:0]  REG_SPARE = 8'd2;
  localparam logic [63:0] ARC_CAP   = 64'h1_0000_0000_0000;
  localparam longint      X_MAX     = (64'sd1 <<< 47) - 1;
  localparam longint      X_MIN     = -(64'sd1 <<< 47);

  localparam logic [31:0] ATAN_TAB [0:23] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};

  typedef struct {
    logic signed [15:0] x_cm;
    logic signed [15:0] y_cm;
    logic [31:0]        hdg;
  } pose_t;

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;
  typedef struct {
    row_kind_t          kind;
    logic [7:0]         idx;
    logic [15:0]        data;
    logic signed [11:0] lt;
    logic signed [11:0] rt;
    bit                 typed;
    pose_t              want;
  } row_t;

  logic clk = 1'b0, rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [7:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic item_valid = 1'b0, item_ready;
  logic signed [TICKS_W-1:0] left_ticks = '0, right_ticks = '0;
  logic result_valid, result_ready = 1'b0;
  logic signed [15:0] pos_x_cm, pos_y_cm;
  logic [31:0] heading_angle;

  differential_drive_odometry_unit DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state and register copies.
  logic [15:0] tick_len = TICK_LENGTH_RESET, inv_track = INV_TRACK_WIDTH_RESET;
  longint px = 0, py = 0;
  logic [31:0] hdg = '0;

  pose_t pose_q[$];
  int errors = 0, results_seen = 0, items_sent = 0, cycles = 0;
  int tx_idle = 0, rx_idle = 0;
  bit typed_now = 0;
  pose_t typed_pose;

  function automatic logic [63:0] mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint capped(logic [127:0] m, bit neg);
    longint c;
    c = (m > 128'(ARC_CAP)) ? longint'(ARC_CAP) : longint'(m[63:0]);
    return neg ? -c : c;
  endfunction

  function automatic longint sat_add(longint p, longint d);
    longint r;
    r = p + d;
    if (r > X_MAX) r = X_MAX;
    if (r < X_MIN) r = X_MIN;
    return r;
  endfunction

  function automatic logic [15:0] whole_cm(longint p);
    longint w;
    w = p < 0 ? -((-p) >>> 16) : (p >>> 16);
    if (w > 32767) w = 32767;
    if (w < -32768) w = -32768;
    return w[15:0];
  endfunction

  task automatic sin_cos(input logic [31:0] ang, output longint sn, output longint cs);
    logic [31:0] u;
    longint z, x, y, xs, ys;
    bit flip;
    u = ang;
    flip = 0;
    x = 652032874;
    y = 0;
    z = longint'($signed(u));
    // Angles beyond a quarter turn are rotated by half a turn first.
    if (z > (64'sd1 <<< 30) || z < -(64'sd1 <<< 30)) begin
      u = u ^ 32'h80000000;
      z = longint'($signed(u));
      flip = 1;
    end
    for (int i = 0; i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - longint'(ATAN_TAB[i]);
      end else begin
        x = x + ys; y = y - xs; z = z + longint'(ATAN_TAB[i]);
      end
    end
    sn = flip ? -y : y;
    cs = flip ? -x : x;
  endtask

  task automatic advance_pose(input logic signed [11:0] lt, input logic signed [11:0] rt,
                              output pose_t res);
    longint dl, dr, s, p, t, s0, c0, s1, c1, dc, ds;
    logic [127:0] tm, nx, ny;
    logic [31:0] hn;
    dl = longint'(lt) * longint'(tick_len);
    dr = longint'(rt) * longint'(tick_len);
    s = dl + dr;
    p = (dl - dr) * longint'(inv_track);
    tm = (128'(mag(p)) * 128'(683565276)) >> 32;
    t = p < 0 ? -longint'(tm[63:0]) : longint'(tm[63:0]);
    sin_cos(hdg, s0, c0);
    if (t == 0) begin
      nx = (128'(mag(s)) * 128'(mag(s0))) >> 31;
      ny = (128'(mag(s)) * 128'(mag(c0))) >> 31;
      px = sat_add(px, capped(nx, (s < 0) != (s0 < 0)));
      py = sat_add(py, capped(ny, (s < 0) != (c0 < 0)));
    end else begin
      // Arc step: chord from the change of sine and cosine over the unwrapped turn.
      hn = hdg + t[31:0];
      sin_cos(hn, s1, c1);
      dc = c0 - c1;
      ds = s1 - s0;
      nx = (128'(mag(s)) * 128'(mag(dc)) * 128'(32'd2734261102)) / 128'(mag(t));
      ny = (128'(mag(s)) * 128'(mag(ds)) * 128'(32'd2734261102)) / 128'(mag(t));
      px = sat_add(px, capped(nx >> 33, ((s < 0) != (dc < 0)) != (t < 0)));
      py = sat_add(py, capped(ny >> 33, ((s < 0) != (ds < 0)) != (t < 0)));
      hdg = hn;
    end
    res.x_cm = whole_cm(px);
    res.y_cm = whole_cm(py);
    res.hdg = hdg;
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch on result %0d, %s: got %0h, expected %0h",
             results_seen, field, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    pose_t nxt, exp_pose;
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_top failed");
      $finish;
    end else if (!rst) begin
      if (item_valid && item_ready) begin
        advance_pose(left_ticks, right_ticks, nxt);
        pose_q.push_back(typed_now ? typed_pose : nxt);
        items_sent++;
      end
      if (result_valid && result_ready) begin
        if (pose_q.size() == 0) begin
          $display("result transaction with no expectation waiting");
          errors++;
        end else begin
          exp_pose = pose_q.pop_front();
          if (pos_x_cm !== exp_pose.x_cm) report_mismatch("pos_x_cm", pos_x_cm, exp_pose.x_cm);
          if (pos_y_cm !== exp_pose.y_cm) report_mismatch("pos_y_cm", pos_y_cm, exp_pose.y_cm);
          if (heading_angle !== exp_pose.hdg)
            report_mismatch("heading_angle", heading_angle, exp_pose.hdg);
        end
        results_seen++;
      end
    end
  end

  always @(negedge clk) begin
    result_ready <= !rst && ($urandom_range(99) >= rx_idle);
  end

  task automatic write_reg(input logic [7:0] idx, input logic [15:0] data);
    // Only while idle: all results back, plus margin for the longest step.
    item_valid <= 1'b0;
    wait (pose_q.size() == 0);
    repeat (500) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    if (idx == REG_TICK_LENGTH) tick_len = data;
    else if (idx == REG_INV_TRACK_WIDTH) inv_track = data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Valid is left high after the handshake; whatever the driver does next
  // at this falling edge either drops it or presents the next transaction.
  task automatic send_item(input logic signed [11:0] lt, input logic signed [11:0] rt);
    while ($urandom_range(99) < tx_idle) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    left_ticks <= lt;
    right_ticks <= rt;
    do @(posedge clk); while (!(item_valid && item_ready));
    @(negedge clk);
    typed_now = 0;
  endtask

  function automatic logic signed [11:0] rand_ticks();
    // Mostly short moves so the pose wanders without pinning at saturation.
    case ($urandom_range(9))
      0, 1:    return 12'($urandom);
      2:       return $urandom_range(1) ? 12'sd2047 : -12'sd2048;
      default: return 12'($signed(6'($urandom)));
    endcase
  endfunction

  row_t rows[$];

  initial begin
    pose_t zero_pose;
    zero_pose = '{0, 0, 0};
    rows = '{
      '{ROW_ITEM, 0, 0, 0, 0, 1, zero_pose},
      '{ROW_ITEM, 0, 0, 2047, 2047, 0, zero_pose},
      '{ROW_ITEM, 0, 0, -2048, -2048, 0, zero_pose},
      '{ROW_ITEM, 0, 0, 2047, -2048, 0, zero_pose},
      '{ROW_ITEM, 0, 0, -2048, 2047, 0, zero_pose},
      '{ROW_ITEM, 0, 0, 1, -1, 0, zero_pose},
      '{ROW_ITEM, 0, 0, -1, 1, 0, zero_pose},
      '{ROW_ITEM, 0, 0, 100, 100, 0, zero_pose},
      '{ROW_CFG, REG_TICK_LENGTH, 16'hFFFF, 0, 0, 0, zero_pose},
      '{ROW_CFG, REG_INV_TRACK_WIDTH, 16'hFFFF, 0, 0, 0, zero_pose},
      '{ROW_ITEM, 0, 0, 2047, -2048, 0, zero_pose},
      '{ROW_ITEM, 0, 0, 2047, 2047, 0, zero_pose},
      '{ROW_ITEM, 0, 0, 2047, 2047, 0, zero_pose},
      '{ROW_ITEM, 0, 0, 2047, 2047, 0, zero_pose},
      '{ROW_ITEM, 0, 0, 2047, 2047, 0, zero_pose},
      '{ROW_CFG, REG_INV_TRACK_WIDTH, 16'h0000, 0, 0, 0, zero_pose},
      '{ROW_ITEM, 0, 0, 2047, -2048, 0, zero_pose},
      '{ROW_ITEM, 0, 0, -1, 1, 0, zero_pose},
      '{ROW_CFG, REG_TICK_LENGTH, 16'h0001, 0, 0, 0, zero_pose},
      '{ROW_CFG, REG_INV_TRACK_WIDTH, 16'h0001, 0, 0, 0, zero_pose},
      '{ROW_ITEM, 0, 0, 1, 0, 0, zero_pose},
      '{ROW_ITEM, 0, 0, 0, 1, 0, zero_pose},
      '{ROW_CFG, REG_TICK_LENGTH, 16'h0000, 0, 0, 0, zero_pose},
      '{ROW_ITEM, 0, 0, 2047, -2048, 0, zero_pose},
      '{ROW_CFG, REG_SPARE, 16'h1234, 0, 0, 0, zero_pose},
      '{ROW_CFG, REG_TICK_LENGTH, TICK_LENGTH_RESET, 0, 0, 0, zero_pose},
      '{ROW_CFG, REG_INV_TRACK_WIDTH, INV_TRACK_WIDTH_RESET, 0, 0, 0, zero_pose}
    };

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    tx_idle = 6;
    rx_idle = 64;
    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        write_reg(rows[i].idx, rows[i].data);
      end else begin
        typed_now = rows[i].typed;
        typed_pose = rows[i].want;
        send_item(rows[i].lt, rows[i].rt);
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      tx_idle = (ph == 0) ? 6 : (ph == 1) ? 64 : 0;
      rx_idle = (ph == 0) ? 64 : (ph == 1) ? 6 : 0;
      write_reg(REG_TICK_LENGTH, (ph == 1) ? 16'hFFFF : 16'($urandom));
      write_reg(REG_INV_TRACK_WIDTH, (ph == 2) ? 16'h0000 : 16'($urandom));
      for (int n = 0; n < 275; n++) send_item(rand_ticks(), rand_ticks());
    end

    item_valid <= 1'b0;
    wait (pose_q.size() == 0);
    repeat (600) @(posedge clk);
    $display("covered %0d item transactions and %0d results over three idling phases,",
             items_sent, results_seen);
    $display("with register settings from zero to full scale in %0d cycles", cycles);
    if (errors == 0 && pose_q.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end
endmodule

`default_nettype wire
